@@ rtl/assert_macros.svh @@
// Assertion macros shared by the pairing search RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication at each clock edge outside reset.
`define CHECK_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed: label");
// Check an implication in the next cycle.
`define CHECK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed: label");
`endif

@@ rtl/bpbb_pkg.sv @@
// Package for the best pairing search: state codes, commands, widths.
// Depends on nothing.
`default_nettype none
package bpbb_pkg;
    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [1:0] CMD_SEARCH      = 2'd2;
    localparam logic [1:0] CMD_RESERVED    = 2'd3;
    localparam int MAX_PAIRS = 8;
    localparam int SUM_W = 20;
    localparam int TOTAL_W = 19;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BINIT, ST_BRD, ST_BMUL, ST_BACC, ST_BCHK,
        ST_TRY, ST_GRD, ST_GMUL, ST_GO, ST_LEAF, ST_EMIT
    } state_t;
endpackage
`default_nettype wire

@@ rtl/bpbb_mul.sv @@
// Shared registered 8x8 multiplier for the search datapath.
// Depends on nothing.
`default_nettype none
module bpbb_mul (
    input  wire logic        aclk,
    input  wire logic [7:0]  a,
    input  wire logic [7:0]  b,
    output logic      [15:0] p_reg
);
    // register one product per cycle
    always_ff @(posedge aclk) begin
        p_reg <= 16'(a) * 16'(b);
    end
endmodule
`default_nettype wire

@@ rtl/best_pairing_branch_and_bound_top.sv @@
// Top level of the best pairing branch-and-bound search.
// Depends on bpbb_pkg, bpbb_mul and assert_macros.svh.
//
// Load words (command 0 or 1 on tuser) are taken one per cycle. A search word
// runs a depth-first walk under a small sequencer that shares one registered
// 8x8 multiplier for both the pruning bound and the branch gains. The bound at
// a node takes a setup state, read, multiply and accumulate states for each
// remaining row and column pair, and a compare; a free column takes try, read,
// multiply and commit states; skipping a taken column or backing up from an
// exhausted level is one try step, and each leaf or pruned node one leaf step,
// so search time follows the pruned tree. The input is not ready during the
// walk or while the n result words (one per column) are driven from held state.
`default_nettype none
`include "assert_macros.svh"
module best_pairing_branch_and_bound_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tuser: command[1:0]
    input  wire logic [1:0]  s_tuser,
    // tdata: row[2:0], col[5:3], score[13:6], zeros
    input  wire logic [15:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: best_total[18:0], slot_index[21:19], partner_index[24:22], zeros
    output logic [31:0]      m_tdata,
    // tuser: partner_valid
    output logic             m_tuser,
    output logic             m_tlast
);
    localparam int NP = bpbb_pkg::MAX_PAIRS;
    localparam int IW = (NP > 1) ? $clog2(NP) : 1;
    localparam int LW = $clog2(NP + 1);
    localparam int SW = bpbb_pkg::SUM_W;

    logic [7:0] first_mem [NP*NP];
    logic [7:0] second_mem [NP*NP];

    wire logic [1:0] in_cmd = s_tuser;
    wire logic [2:0] in_row = s_tdata[2:0];
    wire logic [2:0] in_col = s_tdata[5:3];
    wire logic [7:0] in_score = s_tdata[13:6];

    bpbb_pkg::state_t state_reg, state_next;
    logic [3:0]   pairs_reg;
    logic [LW-1:0] n_reg, lvl_reg;
    logic [NP-1:0] taken_reg;
    logic [IW-1:0] owner_reg [NP];
    logic [IW-1:0] best_own_reg [NP];
    logic          best_vld_reg;
    logic [SW-1:0] lsum_reg [NP+1];
    logic [LW-1:0] choice_reg [NP];
    logic [SW-1:0] best_reg, bnd_reg;
    logic [15:0]  top_reg;
    logic [LW-1:0] br_reg, bc_reg;
    logic [7:0]   fa_reg, sb_reg;
    logic [15:0]  prod;
    logic [LW-1:0] emit_reg;

    bpbb_mul u_mul (.aclk(aclk), .a(fa_reg), .b(sb_reg), .p_reg(prod));

    wire logic acc_in = s_tvalid && s_tready;
    assign s_tready = (state_reg == bpbb_pkg::ST_IDLE);

    // saturate the configured size
    wire logic [LW-1:0] n_sat = (32'(pairs_reg) > NP) ? LW'(NP) : LW'(pairs_reg);

    // load the matrices
    always_ff @(posedge aclk) begin
        if (acc_in) begin
            if (in_cmd == bpbb_pkg::CMD_LOAD_FIRST)
                first_mem[{in_row, in_col}] <= in_score;
            if (in_cmd == bpbb_pkg::CMD_LOAD_SECOND)
                second_mem[{in_row, in_col}] <= in_score;
        end
    end

    // multiplier operands: first row br_reg, column bc_reg; second transposed
    always_ff @(posedge aclk) begin
        fa_reg <= first_mem[{br_reg[IW-1:0], bc_reg[IW-1:0]}];
        sb_reg <= second_mem[{bc_reg[IW-1:0], br_reg[IW-1:0]}];
    end

    wire logic [SW-1:0] cur_sum = lsum_reg[lvl_reg];
    wire logic last_col = (bc_reg + 1'b1 == n_reg);
    wire logic [LW-1:0] choice_cur = choice_reg[lvl_reg[IW-1:0]];
    wire logic col_better = !taken_reg[bc_reg[IW-1:0]] && prod > top_reg;
    wire logic [15:0] col_top = col_better ? prod : top_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpbb_pkg::ST_IDLE:
                if (acc_in && in_cmd == bpbb_pkg::CMD_SEARCH)
                    state_next = (n_sat == '0) ? bpbb_pkg::ST_IDLE : bpbb_pkg::ST_BINIT;
            bpbb_pkg::ST_BINIT: state_next = bpbb_pkg::ST_BRD;
            bpbb_pkg::ST_BRD:   state_next = bpbb_pkg::ST_BMUL;
            bpbb_pkg::ST_BMUL:  state_next = bpbb_pkg::ST_BACC;
            bpbb_pkg::ST_BACC:
                if (last_col && br_reg + 1'b1 == n_reg) state_next = bpbb_pkg::ST_BCHK;
                else state_next = bpbb_pkg::ST_BRD;
            bpbb_pkg::ST_BCHK:
                if (cur_sum + bnd_reg <= best_reg) state_next = bpbb_pkg::ST_LEAF;
                else state_next = bpbb_pkg::ST_TRY;
            bpbb_pkg::ST_TRY:
                if (choice_cur >= n_reg) begin
                    if (lvl_reg == '0) state_next = bpbb_pkg::ST_EMIT;
                end else if (!taken_reg[choice_cur[IW-1:0]]) begin
                    state_next = bpbb_pkg::ST_GRD;
                end
            bpbb_pkg::ST_GRD:   state_next = bpbb_pkg::ST_GMUL;
            bpbb_pkg::ST_GMUL:  state_next = bpbb_pkg::ST_GO;
            bpbb_pkg::ST_GO:
                state_next = (lvl_reg + 1'b1 == n_reg) ? bpbb_pkg::ST_LEAF
                                                        : bpbb_pkg::ST_BINIT;
            bpbb_pkg::ST_LEAF:
                state_next = (lvl_reg == '0) ? bpbb_pkg::ST_EMIT : bpbb_pkg::ST_TRY;
            bpbb_pkg::ST_EMIT:
                if (m_tready && emit_reg + 1'b1 == n_reg) state_next = bpbb_pkg::ST_IDLE;
            default: state_next = bpbb_pkg::ST_IDLE;
        endcase
    end

    // walk sequencer datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpbb_pkg::ST_IDLE;
            pairs_reg <= 4'd8;
            taken_reg <= '0;
            emit_reg <= '0;
            best_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) pairs_reg <= cfg_wdata;
            case (state_reg)
                bpbb_pkg::ST_IDLE: if (acc_in && in_cmd == bpbb_pkg::CMD_SEARCH) begin
                    n_reg <= n_sat;
                    lvl_reg <= '0;
                    taken_reg <= '0;
                    best_reg <= '0;
                    best_vld_reg <= 1'b0;
                    emit_reg <= '0;
                    lsum_reg[0] <= '0;
                    for (int i = 0; i < NP; i++) begin
                        owner_reg[i] <= '0;
                        best_own_reg[i] <= '0;
                    end
                end
                bpbb_pkg::ST_BINIT: begin
                    bnd_reg <= '0;
                    top_reg <= '0;
                    br_reg <= lvl_reg;
                    bc_reg <= '0;
                end
                bpbb_pkg::ST_BMUL: ;
                bpbb_pkg::ST_BACC: begin
                    if (last_col) begin
                        bnd_reg <= bnd_reg + SW'(col_top);
                        top_reg <= '0;
                        bc_reg <= '0;
                        br_reg <= br_reg + 1'b1;
                    end else begin
                        if (col_better) top_reg <= prod;
                        bc_reg <= bc_reg + 1'b1;
                    end
                end
                bpbb_pkg::ST_BCHK: begin
                    choice_reg[lvl_reg[IW-1:0]] <= '0;
                end
                bpbb_pkg::ST_TRY: begin
                    // find next free column at this level, or back up
                    if (choice_cur >= n_reg) begin
                        if (lvl_reg != '0) begin
                            lvl_reg <= lvl_reg - 1'b1;
                            taken_reg[choice_reg[IW'(lvl_reg - 1'b1)][IW-1:0]] <= 1'b0;
                            owner_reg[choice_reg[IW'(lvl_reg - 1'b1)][IW-1:0]] <= '0;
                            choice_reg[IW'(lvl_reg - 1'b1)] <= choice_reg[IW'(lvl_reg - 1'b1)] + 1'b1;
                        end
                    end else if (taken_reg[choice_cur[IW-1:0]]) begin
                        choice_reg[lvl_reg[IW-1:0]] <= choice_cur + 1'b1;
                    end else begin
                        br_reg <= lvl_reg;
                        bc_reg <= choice_cur;
                    end
                end
                bpbb_pkg::ST_GO: begin
                    taken_reg[bc_reg[IW-1:0]] <= 1'b1;
                    owner_reg[bc_reg[IW-1:0]] <= lvl_reg[IW-1:0];
                    lsum_reg[lvl_reg + 1'b1] <= cur_sum + SW'(prod);
                    lvl_reg <= lvl_reg + 1'b1;
                end
                bpbb_pkg::ST_LEAF: begin
                    if (lvl_reg == n_reg && cur_sum > best_reg) begin
                        best_reg <= cur_sum;
                        best_vld_reg <= 1'b1;
                        for (int i = 0; i < NP; i++) best_own_reg[i] <= owner_reg[i];
                    end
                    // return to parent and advance its choice
                    if (lvl_reg != '0) begin
                        lvl_reg <= lvl_reg - 1'b1;
                        taken_reg[choice_reg[IW'(lvl_reg - 1'b1)][IW-1:0]] <= 1'b0;
                        owner_reg[choice_reg[IW'(lvl_reg - 1'b1)][IW-1:0]] <= '0;
                        choice_reg[IW'(lvl_reg - 1'b1)] <= choice_reg[IW'(lvl_reg - 1'b1)] + 1'b1;
                    end
                end
                bpbb_pkg::ST_EMIT: if (m_tready) emit_reg <= emit_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // drive the result word straight from held state
    assign m_tvalid = (state_reg == bpbb_pkg::ST_EMIT);
    assign m_tlast  = (emit_reg + 1'b1 == n_reg);
    assign m_tuser  = best_vld_reg;
    assign m_tdata  = {7'd0,
                       best_vld_reg ? 3'(best_own_reg[emit_reg[IW-1:0]]) : 3'd0,
                       3'(emit_reg), best_reg[bpbb_pkg::TOTAL_W-1:0]};

    `CHECK_IMPL(a_busy_not_ready, aclk, aresetn, state_reg != bpbb_pkg::ST_IDLE, !s_tready)
    `CHECK_IMPL(a_lvl_range, aclk, aresetn, state_reg != bpbb_pkg::ST_IDLE, lvl_reg <= n_reg)
    `CHECK_NEXT(a_emit_end, aclk, aresetn, m_tvalid && m_tready && m_tlast, state_reg == bpbb_pkg::ST_IDLE)
endmodule
`default_nettype wire
